// ===== rtl/cltok_pkg.sv =====
// Shared types, codes and character classes of the command line tokenizer.
package cltok_pkg;

  localparam int MAX_TOKENS_DEF    = 128;
  localparam int MAX_TOKEN_LEN_DEF = 127;
  localparam int OUTQ_DEPTH        = 4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_INT    = 2'd1;
  localparam logic [1:0] KIND_IDENT  = 2'd2;
  localparam logic [1:0] KIND_OP     = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef struct packed {
    logic [7:0]         char_out;
    logic [1:0]         token_kind;
    logic               token_first;
    logic [6:0]         token_index;
    logic signed [31:0] int_value;
    logic               line_done;
    logic [1:0]         line_status;
  } result_t;

  // Up to two results per byte, in delivery order: a first, then b.
  typedef struct packed {
    logic [1:0] count;
    result_t    a;
    result_t    b;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c inside {CH_EQUAL, CH_LBRACE, CH_RBRACE, CH_COMMA};
  endfunction

endpackage

// ===== rtl/cltok_lexer.sv =====
// Lexer state and the per-byte classification and result forming logic.
module cltok_lexer #(
  parameter int MAX_TOKENS    = cltok_pkg::MAX_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = cltok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      char_byte,
  input  logic            last_char,
  output cltok_pkg::push_t push
);
  import cltok_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_IDENT
  } mode_t;

  localparam logic [7:0] MAX_TOK = 8'(MAX_TOKENS);
  localparam logic [6:0] MAX_LEN = 7'(MAX_TOKEN_LEN);

  mode_t       lex_mode, lex_mode_next;
  logic [7:0]  token_count, token_count_next;
  logic [6:0]  token_len, token_len_next;
  logic [31:0] accum_value, accum_value_next;
  logic        negative_flag, negative_flag_next;
  logic [1:0]  error_code, error_code_next;

  logic        dig, alpha, space, op, minus;
  logic [3:0]  digit;
  logic [35:0] prod;
  logic [31:0] limit, sat;
  logic        tok_valid;
  result_t     tok, stat;

  assign dig   = is_digit(char_byte);
  assign alpha = is_alpha(char_byte);
  assign space = is_space(char_byte);
  assign op    = is_op(char_byte);
  assign minus = (char_byte == CH_MINUS);
  assign digit = char_byte[3:0];

  // Magnitude times ten plus the new digit, clamped to the signed range.
  assign prod  = {1'b0, accum_value, 3'b000} + {3'b000, accum_value, 1'b0} + 36'(digit);
  assign limit = negative_flag ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat   = (prod > {4'd0, limit}) ? limit : prod[31:0];

  always_comb begin
    lex_mode_next      = lex_mode;
    token_count_next   = token_count;
    token_len_next     = token_len;
    accum_value_next   = accum_value;
    negative_flag_next = negative_flag;
    error_code_next    = error_code;
    tok_valid          = 1'b0;
    tok                = '0;
    tok.char_out       = char_byte;
    tok.token_index    = 7'(token_count - 8'd1);

    if (error_code == STATUS_OK) begin
      if ((lex_mode == MODE_INT && dig) ||
          (lex_mode == MODE_IDENT && (alpha || dig || char_byte == CH_UNDER))) begin
        if (token_len >= MAX_LEN) begin
          error_code_next = STATUS_TOO_LONG;
          lex_mode_next   = MODE_IDLE;
        end else begin
          token_len_next = token_len + 7'd1;
          tok_valid      = 1'b1;
          if (lex_mode == MODE_INT) begin
            accum_value_next = sat;
            tok.token_kind   = KIND_INT;
            tok.int_value    = negative_flag ? $signed(32'd0 - sat) : $signed(sat);
          end else begin
            tok.token_kind = KIND_IDENT;
          end
        end
      end else begin
        lex_mode_next = MODE_IDLE;
        if (space) begin
          // Separator only.
        end else if (!(dig || minus || alpha || op)) begin
          error_code_next = STATUS_BAD_CHAR;
        end else if (token_count >= MAX_TOK) begin
          error_code_next = STATUS_TOO_MANY;
        end else begin
          token_count_next = token_count + 8'd1;
          token_len_next   = 7'd1;
          tok_valid        = 1'b1;
          tok.token_first  = 1'b1;
          tok.token_index  = token_count[6:0];
          if (dig || minus) begin
            tok.token_kind     = KIND_INT;
            negative_flag_next = minus;
            accum_value_next   = minus ? 32'd0 : {28'd0, digit};
            tok.int_value      = minus ? 32'sd0 : $signed({28'd0, digit});
            lex_mode_next      = MODE_INT;
          end else if (alpha) begin
            tok.token_kind = KIND_IDENT;
            lex_mode_next  = MODE_IDENT;
          end else begin
            tok.token_kind = KIND_OP;
          end
        end
      end
    end

    stat             = '0;
    stat.line_done   = 1'b1;
    stat.line_status = error_code_next;

    if (last_char) begin
      lex_mode_next      = MODE_IDLE;
      token_count_next   = '0;
      token_len_next     = '0;
      accum_value_next   = '0;
      negative_flag_next = 1'b0;
      error_code_next    = STATUS_OK;
    end

    push.count = {1'b0, tok_valid} + {1'b0, last_char};
    push.a     = tok_valid ? tok : stat;
    push.b     = stat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= MODE_IDLE;
      token_count   <= '0;
      token_len     <= '0;
      accum_value   <= '0;
      negative_flag <= 1'b0;
      error_code    <= STATUS_OK;
    end else if (step) begin
      lex_mode      <= lex_mode_next;
      token_count   <= token_count_next;
      token_len     <= token_len_next;
      accum_value   <= accum_value_next;
      negative_flag <= negative_flag_next;
      error_code    <= error_code_next;
    end
  end

endmodule

// ===== rtl/cltok_outq.sv =====
// Result queue that takes up to two results per cycle and hands out one per cycle while not stalled.
module cltok_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  cltok_pkg::push_t  push,
  output logic              room,
  output logic              valid,
  input  logic              stall,
  output cltok_pkg::result_t head
);
  import cltok_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);

  result_t       mem [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill, fill_next;
  logic [1:0]    n_in;
  logic          pop;

  assign n_in  = push_en ? push.count : 2'd0;
  assign pop   = valid && !stall;
  assign valid = (fill != '0);
  assign room  = (fill <= (PW+1)'(OUTQ_DEPTH - 2));
  assign head  = mem[rd_ptr];
  assign fill_next = fill + (PW+1)'(n_in) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_ptr] <= push.a;
    end
    if (n_in == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_in);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill_next;
    end
  end

endmodule

// ===== rtl/command_line_tokenizer_unit.sv =====
// Top level of the command line tokenizer: input register, lexer and result queue.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------------------------
//   input   | in_valid, in_stall | char_byte, last_char
//   output  | out_valid,         | char_out, token_kind, token_first, token_index,
//           | out_stall          | int_value, line_done, line_status
//
// One byte is lexed per cycle while the result queue has room: a byte is held
// in the input register, its results are written into the queue when it is
// lexed, and they leave in order from the queue head.
// A byte is lexed only when the four-entry result queue has room for two
// results, which is what sets the rate when the output side stalls; a closing
// byte yields a line status result after its own token result, if any.
// Reset (rst, synchronous) returns the lexer to the state between lines and
// empties the queue; the queue storage itself is not cleared.
module command_line_tokenizer_unit #(
  parameter int MAX_TOKENS    = cltok_pkg::MAX_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = cltok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_byte,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         char_out,
  output logic [1:0]         token_kind,
  output logic               token_first,
  output logic [6:0]         token_index,
  output logic signed [31:0] int_value,
  output logic               line_done,
  output logic [1:0]         line_status
);
  import cltok_pkg::*;

  // Input register: holds one byte until the queue can take its results.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       step;
  logic       room;
  push_t      push;
  result_t    head;

  // The held byte is lexed whenever the queue has room for two results, so
  // in_stall only rises while a byte waits on a nearly full queue.
  assign step     = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= char_byte;
      in_last <= last_char;
    end
  end

  cltok_lexer #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_byte (in_byte),
    .last_char (in_last),
    .push      (push)
  );

  // The queue decouples the two sides; its head is the output payload and
  // stays put while the consumer stalls.
  cltok_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push_en (step),
    .push    (push),
    .room    (room),
    .valid   (out_valid),
    .stall   (out_stall),
    .head    (head)
  );

  assign char_out    = head.char_out;
  assign token_kind  = head.token_kind;
  assign token_first = head.token_first;
  assign token_index = head.token_index;
  assign int_value   = head.int_value;
  assign line_done   = head.line_done;
  assign line_status = head.line_status;

endmodule
